// File: sv/gsp_pkg.sv
// shared types and constants for the geometry string parser
// no dependencies

package gsp_pkg;

   localparam logic [3:0] PH_START  = 4'd0;
   localparam logic [3:0] PH_WSTART = 4'd1;
   localparam logic [3:0] PH_WNUM   = 4'd2;
   localparam logic [3:0] PH_HSTART = 4'd3;
   localparam logic [3:0] PH_HNUM   = 4'd4;
   localparam logic [3:0] PH_XSTART = 4'd5;
   localparam logic [3:0] PH_XNUM   = 4'd6;
   localparam logic [3:0] PH_YSTART = 4'd7;
   localparam logic [3:0] PH_YNUM   = 4'd8;
   localparam logic [3:0] PH_ERR    = 4'd9;

   localparam logic [3:0] BIT_X = 4'b0001;
   localparam logic [3:0] BIT_Y = 4'b0010;
   localparam logic [3:0] BIT_W = 4'b0100;
   localparam logic [3:0] BIT_H = 4'b1000;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [15:0] RADIX = 16'd10;

   typedef struct packed {
      logic [3:0]  phase;
      logic [15:0] accum;
      logic        negate;
      logic [3:0]  seen_mask;
      logic [15:0] held_x;
      logic [15:0] held_y;
      logic [15:0] held_w;
      logic [15:0] held_h;
   } parse_state_type;

   typedef struct packed {
      logic [3:0]  part_mask;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] size_w;
      logic [15:0] size_h;
   } parse_result_type;

   localparam parse_state_type STATE_RESET = '{
      phase: PH_START, accum: 16'd0, negate: 1'b0, seen_mask: 4'd0,
      held_x: 16'd0, held_y: 16'd0, held_w: 16'd0, held_h: 16'd0
   };

endpackage

// File: sv/gsp_step.sv
// one character step of the parser: next state and optional result
// depends on gsp_pkg

module gsp_step import gsp_pkg::*; (
   input  logic [7:0]       ch,
   input  parse_state_type  cur,
   output parse_state_type  nxt,
   output logic             emit,
   output parse_result_type result
);

   parse_state_type st;
   logic            is_digit;
   logic            is_sign;
   logic [15:0]     dval;
   logic [15:0]     value_now;
   logic            do_fail;
   logic            do_emit;
   logic            ws;
   logic            ap;
   logic [1:0]      ap_stage;
   logic            ns;
   logic [3:0]      ns_phase;

   always_comb begin
      st       = cur;
      is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
      dval     = {12'd0, ch[3:0]};
      value_now = cur.negate ? (16'd0 - cur.accum) : cur.accum;
      do_fail  = 1'b0;
      do_emit  = 1'b0;
      ws       = 1'b0;
      ap       = 1'b0;
      ap_stage = 2'd0;
      ns       = 1'b0;
      ns_phase = PH_HNUM;

      unique case (cur.phase)
         PH_START: begin
            if (ch == CH_NUL) begin
               do_emit = 1'b1;
            end else if (ch == CH_EQ) begin
               st.phase = PH_WSTART;
            end else begin
               ws = 1'b1;
            end
         end
         PH_WSTART: begin
            ws = 1'b1;
         end
         PH_WNUM: begin
            if (is_digit) begin
               st.accum = st.accum * RADIX + dval;
            end else begin
               st.held_w    = cur.accum;
               st.seen_mask = st.seen_mask | BIT_W;
               ap           = 1'b1;
               ap_stage     = 2'd0;
            end
         end
         PH_HSTART: begin
            ns       = 1'b1;
            ns_phase = PH_HNUM;
         end
         PH_HNUM: begin
            if (is_digit) begin
               st.accum = st.accum * RADIX + dval;
            end else begin
               st.held_h    = value_now;
               st.seen_mask = st.seen_mask | BIT_H;
               ap           = 1'b1;
               ap_stage     = 2'd1;
            end
         end
         PH_XSTART: begin
            ns       = 1'b1;
            ns_phase = PH_XNUM;
         end
         PH_XNUM: begin
            if (is_digit) begin
               st.accum = st.accum * RADIX + dval;
            end else begin
               st.held_x    = value_now;
               st.seen_mask = st.seen_mask | BIT_X;
               ap           = 1'b1;
               ap_stage     = 2'd2;
            end
         end
         PH_YSTART: begin
            ns       = 1'b1;
            ns_phase = PH_YNUM;
         end
         PH_YNUM: begin
            if (is_digit) begin
               st.accum = st.accum * RADIX + dval;
            end else begin
               st.held_y    = value_now;
               st.seen_mask = st.seen_mask | BIT_Y;
               ap           = 1'b1;
               ap_stage     = 2'd3;
            end
         end
         default: begin
            do_fail = 1'b1;
         end
      endcase

      // first character of the geometry: width digit, x lead or sign of a position
      if (ws) begin
         if (is_sign) begin
            st.phase  = PH_XSTART;
            st.accum  = 16'd0;
            st.negate = (ch == CH_MINUS);
         end else if (ch == CH_LX) begin
            st.phase  = PH_HSTART;
            st.accum  = 16'd0;
            st.negate = 1'b0;
         end else if (is_digit) begin
            st.phase  = PH_WNUM;
            st.accum  = dval;
            st.negate = 1'b0;
         end else begin
            do_fail = 1'b1;
         end
      end

      // character that ends a part
      if (ap) begin
         if (ch == CH_NUL) begin
            do_emit = 1'b1;
         end else if ((ap_stage == 2'd0) && ((ch == CH_LX) || (ch == CH_UX))) begin
            st.phase  = PH_HSTART;
            st.accum  = 16'd0;
            st.negate = 1'b0;
         end else if ((ap_stage <= 2'd1) && is_sign) begin
            st.phase  = PH_XSTART;
            st.accum  = 16'd0;
            st.negate = (ch == CH_MINUS);
         end else if ((ap_stage == 2'd2) && is_sign) begin
            st.phase  = PH_YSTART;
            st.accum  = 16'd0;
            st.negate = (ch == CH_MINUS);
         end else begin
            do_fail = 1'b1;
         end
      end

      // first character after a part lead, inner sign allowed
      if (ns) begin
         if (ch == CH_PLUS) begin
            st.phase = ns_phase;
         end else if (ch == CH_MINUS) begin
            st.phase  = ns_phase;
            st.negate = !st.negate;
         end else if (is_digit) begin
            st.phase = ns_phase;
            st.accum = st.accum * RADIX + dval;
         end else begin
            do_fail = 1'b1;
         end
      end

      if (do_fail) begin
         if (ch == CH_NUL) begin
            st.seen_mask = 4'd0;
            do_emit      = 1'b1;
         end else begin
            st.phase = PH_ERR;
         end
      end

      result.part_mask = st.seen_mask;
      result.pos_x     = (st.seen_mask & BIT_X) != 4'd0 ? st.held_x : 16'd0;
      result.pos_y     = (st.seen_mask & BIT_Y) != 4'd0 ? st.held_y : 16'd0;
      result.size_w    = (st.seen_mask & BIT_W) != 4'd0 ? st.held_w : 16'd0;
      result.size_h    = (st.seen_mask & BIT_H) != 4'd0 ? st.held_h : 16'd0;
      emit             = do_emit;
      nxt              = do_emit ? STATE_RESET : st;
   end

endmodule

// File: sv/geometry_string_parser.sv
// geometry string parser: one character per item, one result per NUL
// a NUL item passes the input register, then its result the result register to rsp_
// throughput: one item per cycle; an item waits in the input register only
// while the result register holds an item that is not taken
// reset: synchronous, clears both registers' valid flags and the parse state
// depends on gsp_pkg and gsp_step

module geometry_string_parser import gsp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_part_mask,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [15:0]        rsp_size_w,
   output logic [15:0]        rsp_size_h
);

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0]       in_ch_ff;
   parse_state_type  state_ff;
   parse_state_type  state_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   parse_result_type result_ff;
   parse_result_type step_result;
   logic             step_emit;
   logic             advance;

   gsp_step u_step (
      .ch     (in_ch_ff),
      .cur    (state_ff),
      .nxt    (state_in),
      .emit   (step_emit),
      .result (step_result)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && step_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff <= req_ch;
      end
      if (advance && step_emit) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_part_mask = result_ff.part_mask;
   assign rsp_pos_x     = result_ff.pos_x;
   assign rsp_pos_y     = result_ff.pos_y;
   assign rsp_size_w    = result_ff.size_w;
   assign rsp_size_h    = result_ff.size_h;

endmodule
